>>> rtl/fqrs_pkg.sv
// Shared types and constants for the FASTQ read statistics block.
package fqrs_pkg;

   // Position of a mate within its four-line FASTQ record.
   typedef enum logic [1:0] {
      PH_HEADER    = 2'd0,
      PH_SEQUENCE  = 2'd1,
      PH_SEPARATOR = 2'd2,
      PH_QUALITY   = 2'd3
   } line_phase_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_PHRED_OFFSET = 2'd0,
      CSR_Q_LOW        = 2'd1,
      CSR_Q_HIGH       = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   localparam logic [7:0] PHRED_OFFSET_RESET = 8'd33;
   localparam logic [7:0] Q_LOW_RESET        = 8'd20;
   localparam logic [7:0] Q_HIGH_RESET       = 8'd30;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_G       = 8'h47;
   localparam logic [7:0] CHAR_T       = 8'h54;
   localparam logic [7:0] CHAR_N       = 8'h4E;

   // Counter slots of one mate, in the order they appear on the result bus.
   localparam int CNT_READ   = 0;
   localparam int CNT_BASE   = 1;
   localparam int CNT_A      = 2;
   localparam int CNT_C      = 3;
   localparam int CNT_G      = 4;
   localparam int CNT_T      = 5;
   localparam int CNT_N      = 6;
   localparam int CNT_Q_LOW  = 7;
   localparam int CNT_Q_HIGH = 8;
   localparam int CNT_NUM    = 9;

   localparam int OUT_WIDTH = 40;
   localparam int MATE_NUM  = 2;

endpackage

>>> rtl/fqrs_sat_counter.sv
// Saturating event counter that also presents its next value.
module fqrs_sat_counter #(
   parameter int WIDTH = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             inc,
   output logic [WIDTH-1:0] count_next
);

   logic [WIDTH-1:0] count_ff;
   logic [WIDTH-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (inc && (count_ff != '1)) begin
         count_in = count_ff + WIDTH'(1);
      end
   end

   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/fastq_read_statistics.sv
// Top level of the FASTQ base and quality statistics block.
//
// FASTQ text enters on the req_ stream one byte per transfer, with the paired-end
// mate number in req_tuser. Each mate tracks its own line within the four-line
// record and its own saturating counters. Sequence lines count bases and the
// letters A, C, G, T and N; quality lines count bytes whose Phred score reaches
// each of two thresholds. The newline that ends a quality line produces one
// transfer on the rsp_ stream carrying that mate's totals.
// The csr_ channel writes the Phred offset and the two thresholds; it is always
// ready and must only be used while the block is idle.
// Throughput is one byte per clock except when a stall holds the input register,
// as described below. The newline that causes a result passes through the input
// register, and the result through the result register. The input register updates the per-mate counters.
// When rsp_tready is low and a result is waiting, bytes that produce no result
// keep flowing; a byte that would produce a second result waits in the input
// register and req_tready drops until the waiting result is taken.
// Reset clears all counters, line positions and valid flags, and restores the
// default offset 33 and thresholds 20 and 30.
module fastq_read_statistics #(
   parameter int COUNT_WIDTH = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // mate
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // read_total, base_total, a_total, c_total, g_total, t_total, n_total,
   // q_low_total, q_high_total
   output logic [359:0] rsp_tdata,
   output logic         rsp_tuser,   // mate_out
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data
);

   localparam int NUM = fqrs_pkg::CNT_NUM;
   localparam int OW  = fqrs_pkg::OUT_WIDTH;

   logic [7:0] phred_offset_ff;
   logic [7:0] q_low_ff;
   logic [7:0] q_high_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_mate_ff;

   fqrs_pkg::line_phase_type phase_ff [fqrs_pkg::MATE_NUM];
   fqrs_pkg::line_phase_type cur_phase;

   logic                   is_newline;
   logic                   s1_emits;
   logic                   s1_fire;
   logic                   req_fire;
   logic [7:0]             score;
   logic [NUM-1:0]         inc_kind;
   logic [NUM-1:0]         inc_mate [fqrs_pkg::MATE_NUM];
   logic [COUNT_WIDTH-1:0] cnt_next [fqrs_pkg::MATE_NUM][NUM];

   logic             rsp_valid_ff;
   logic             rsp_mate_ff;
   logic [NUM*OW-1:0] rsp_data_ff;
   logic [NUM*OW-1:0] rsp_data_in;

   // Counter values too large for the result field report the field maximum.
   function automatic logic [OW-1:0] clip_out(input logic [COUNT_WIDTH-1:0] value);
      logic [63:0] wide;
      wide = 64'(value);
      if (|wide[63:OW]) begin
         return '1;
      end
      return wide[OW-1:0];
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phred_offset_ff <= fqrs_pkg::PHRED_OFFSET_RESET;
         q_low_ff        <= fqrs_pkg::Q_LOW_RESET;
         q_high_ff       <= fqrs_pkg::Q_HIGH_RESET;
      end else if (csr_valid) begin
         unique case (fqrs_pkg::csr_index_type'(csr_index))
            fqrs_pkg::CSR_PHRED_OFFSET: phred_offset_ff <= csr_data;
            fqrs_pkg::CSR_Q_LOW:        q_low_ff        <= csr_data;
            fqrs_pkg::CSR_Q_HIGH:       q_high_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   assign cur_phase  = phase_ff[s1_mate_ff];
   assign is_newline = (s1_byte_ff == fqrs_pkg::CHAR_NEWLINE);
   assign s1_emits   = s1_valid_ff && is_newline && (cur_phase == fqrs_pkg::PH_QUALITY);
   assign s1_fire    = s1_valid_ff && (!s1_emits || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign score      = s1_byte_ff - phred_offset_ff;

   always_comb begin
      inc_kind = '0;
      if (is_newline) begin
         inc_kind[fqrs_pkg::CNT_READ] = (cur_phase == fqrs_pkg::PH_QUALITY);
      end else if (cur_phase == fqrs_pkg::PH_SEQUENCE) begin
         inc_kind[fqrs_pkg::CNT_BASE] = 1'b1;
         inc_kind[fqrs_pkg::CNT_A]    = (s1_byte_ff == fqrs_pkg::CHAR_A);
         inc_kind[fqrs_pkg::CNT_C]    = (s1_byte_ff == fqrs_pkg::CHAR_C);
         inc_kind[fqrs_pkg::CNT_G]    = (s1_byte_ff == fqrs_pkg::CHAR_G);
         inc_kind[fqrs_pkg::CNT_T]    = (s1_byte_ff == fqrs_pkg::CHAR_T);
         inc_kind[fqrs_pkg::CNT_N]    = (s1_byte_ff == fqrs_pkg::CHAR_N);
      end else if (cur_phase == fqrs_pkg::PH_QUALITY) begin
         // Bytes below the offset carry no valid score.
         if (s1_byte_ff >= phred_offset_ff) begin
            inc_kind[fqrs_pkg::CNT_Q_LOW]  = (score >= q_low_ff);
            inc_kind[fqrs_pkg::CNT_Q_HIGH] = (score >= q_high_ff);
         end
      end
   end

   for (genvar m = 0; m < fqrs_pkg::MATE_NUM; m++) begin : g_mate
      assign inc_mate[m] = (s1_fire && (s1_mate_ff == 1'(m))) ? inc_kind : '0;

      for (genvar k = 0; k < NUM; k++) begin : g_cnt
         fqrs_sat_counter #(
            .WIDTH(COUNT_WIDTH)
         ) u_cnt (
            .clock     (clock),
            .reset     (reset),
            .inc       (inc_mate[m][k]),
            .count_next(cnt_next[m][k])
         );
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            phase_ff[m] <= fqrs_pkg::PH_HEADER;
         end else if (s1_fire && is_newline && (s1_mate_ff == 1'(m))) begin
            phase_ff[m] <= fqrs_pkg::line_phase_type'(2'(phase_ff[m] + 2'd1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_tdata;
         s1_mate_ff <= req_tuser;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM; k++) begin
         rsp_data_in[k*OW +: OW] = clip_out(cnt_next[s1_mate_ff][k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_emits) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_emits) begin
         rsp_mate_ff <= s1_mate_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_mate_ff;

endmodule

>>> rtl/fqrs_checker.sv
// Port-level checks for the FASTQ read statistics block, bound to the top level.
module fqrs_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [359:0] rsp_tdata,
   input logic         rsp_tuser
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A fresh result must be preceded by an input transfer.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result appeared without a matching input transfer");

endmodule

bind fastq_read_statistics fqrs_checker u_fqrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
